### rtl/core/qte_pkg.sv
package qte_pkg;

   // component format: signed Q1.14
   localparam int COMP_BITS = 16;
   localparam int ANGLE_OUT_BITS = 16;

   // products in Q28, terms and CORDIC datapath widths
   localparam int PROD_BITS = 32;
   localparam int TERM_BITS = 36;
   localparam int SIN_BITS = 30;
   localparam int RAD_BITS = 57;
   localparam int ROOT_BITS = 29;
   localparam int SQRT_STEPS = 29;
   localparam int CORDIC_BITS = 38;
   localparam int ANGLE_BITS = 34;

   localparam int DEF_CORDIC_STEPS = 16;

   // pi in accumulator units (2^31 = pi)
   localparam logic signed [ANGLE_BITS-1:0] PI_ACC = ANGLE_BITS'(64'sd2147483648);
   localparam logic signed [TERM_BITS-1:0] ONE_Q28 = TERM_BITS'(64'sd268435456);

   typedef struct packed {
      logic signed [COMP_BITS-1:0] quat_w;
      logic signed [COMP_BITS-1:0] quat_x;
      logic signed [COMP_BITS-1:0] quat_y;
      logic signed [COMP_BITS-1:0] quat_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [ANGLE_OUT_BITS-1:0] roll_angle;
      logic signed [ANGLE_OUT_BITS-1:0] pitch_angle;
      logic signed [ANGLE_OUT_BITS-1:0] yaw_angle;
   } rsp_payload_type;

   // atan(2^-i), 2^31 = pi
   function automatic logic signed [ANGLE_BITS-1:0] atan_lut(input int idx);
      logic signed [ANGLE_BITS-1:0] v;
      begin
         case (idx)
            0: v = ANGLE_BITS'(64'sd536870912);
            1: v = ANGLE_BITS'(64'sd316933406);
            2: v = ANGLE_BITS'(64'sd167458907);
            3: v = ANGLE_BITS'(64'sd85004756);
            4: v = ANGLE_BITS'(64'sd42667331);
            5: v = ANGLE_BITS'(64'sd21354465);
            6: v = ANGLE_BITS'(64'sd10679838);
            7: v = ANGLE_BITS'(64'sd5340245);
            8: v = ANGLE_BITS'(64'sd2670163);
            9: v = ANGLE_BITS'(64'sd1335087);
            10: v = ANGLE_BITS'(64'sd667544);
            11: v = ANGLE_BITS'(64'sd333772);
            12: v = ANGLE_BITS'(64'sd166886);
            13: v = ANGLE_BITS'(64'sd83443);
            14: v = ANGLE_BITS'(64'sd41721);
            15: v = ANGLE_BITS'(64'sd20860);
            16: v = ANGLE_BITS'(64'sd10430);
            17: v = ANGLE_BITS'(64'sd5215);
            18: v = ANGLE_BITS'(64'sd2607);
            19: v = ANGLE_BITS'(64'sd1303);
            20: v = ANGLE_BITS'(64'sd651);
            21: v = ANGLE_BITS'(64'sd325);
            22: v = ANGLE_BITS'(64'sd162);
            23: v = ANGLE_BITS'(64'sd81);
            24: v = ANGLE_BITS'(64'sd40);
            25: v = ANGLE_BITS'(64'sd20);
            26: v = ANGLE_BITS'(64'sd10);
            27: v = ANGLE_BITS'(64'sd5);
            28: v = ANGLE_BITS'(64'sd2);
            29: v = ANGLE_BITS'(64'sd1);
            default: v = '0;
         endcase
         return v;
      end
   endfunction

endpackage

### rtl/core/qte_isqrt.sv
module qte_isqrt
   import qte_pkg::*;
(
   input  logic                 clock,
   input  logic                 en,
   input  logic [RAD_BITS-1:0]  rad,
   output logic [ROOT_BITS-1:0] root
);

   // one restoring digit per stage
   logic [RAD_BITS-1:0] v_ff [SQRT_STEPS];
   logic [RAD_BITS-1:0] r_ff [SQRT_STEPS];
   logic [RAD_BITS-1:0] v_in [SQRT_STEPS];
   logic [RAD_BITS-1:0] r_in [SQRT_STEPS];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      localparam logic [RAD_BITS-1:0] Bit = RAD_BITS'(1) << (2 * (SQRT_STEPS - 1 - k));
      logic [RAD_BITS-1:0] v_prev;
      logic [RAD_BITS-1:0] r_prev;
      logic [RAD_BITS-1:0] trial;

      assign v_prev = (k == 0) ? rad : v_ff[(k == 0) ? 0 : k-1];
      assign r_prev = (k == 0) ? '0  : r_ff[(k == 0) ? 0 : k-1];
      assign trial  = r_prev + Bit;

      always_comb begin
         if (v_prev >= trial) begin
            v_in[k] = v_prev - trial;
            r_in[k] = (r_prev >> 1) + Bit;
         end else begin
            v_in[k] = v_prev;
            r_in[k] = r_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            v_ff[k] <= v_in[k];
            r_ff[k] <= r_in[k];
         end
      end
   end

   assign root = r_ff[SQRT_STEPS-1][ROOT_BITS-1:0];

endmodule

### rtl/core/qte_cordic.sv
module qte_cordic
   import qte_pkg::*;
#(
   parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
)
(
   input  logic                             clock,
   input  logic                             en,
   input  logic signed [CORDIC_BITS-1:0]    y_in,
   input  logic signed [CORDIC_BITS-1:0]    x_in,
   output logic signed [ANGLE_OUT_BITS-1:0] angle
);

   // stage 0 folds into the right half plane, stages 1..N rotate
   logic signed [CORDIC_BITS-1:0] x_ff [CORDIC_STEPS+1];
   logic signed [CORDIC_BITS-1:0] y_ff [CORDIC_STEPS+1];
   logic signed [ANGLE_BITS-1:0]  a_ff [CORDIC_STEPS+1];
   logic                          zero_ff [CORDIC_STEPS+1];
   logic signed [ANGLE_OUT_BITS-1:0] angle_ff;
   logic signed [ANGLE_OUT_BITS-1:0] angle_in;

   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff[0] <= (x_in == '0) && (y_in == '0);
         if (x_in < 0) begin
            x_ff[0] <= -x_in;
            y_ff[0] <= -y_in;
            a_ff[0] <= (y_in >= 0) ? PI_ACC : -PI_ACC;
         end else begin
            x_ff[0] <= x_in;
            y_ff[0] <= y_in;
            a_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      localparam logic signed [ANGLE_BITS-1:0] Atan = atan_lut(i);
      logic signed [CORDIC_BITS-1:0] dx;
      logic signed [CORDIC_BITS-1:0] dy;

      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;

      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[i+1] <= zero_ff[i];
            if (y_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               a_ff[i+1] <= a_ff[i] + Atan;
            end else begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               a_ff[i+1] <= a_ff[i] - Atan;
            end
         end
      end
   end

   // round to 16 bits and saturate; a zero vector gives zero
   always_comb begin
      logic signed [ANGLE_BITS:0] rnd;
      logic signed [ANGLE_BITS-16:0] q;
      rnd = {a_ff[CORDIC_STEPS][ANGLE_BITS-1], a_ff[CORDIC_STEPS]} + (ANGLE_BITS+1)'(32768);
      q = rnd[ANGLE_BITS:16];
      if (zero_ff[CORDIC_STEPS])
         angle_in = '0;
      else if (q > (ANGLE_BITS-15)'(32767))
         angle_in = 16'sd32767;
      else if (q < -(ANGLE_BITS-15)'(32768))
         angle_in = -16'sd32768;
      else
         angle_in = q[ANGLE_OUT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         angle_ff <= angle_in;
      end
   end

   assign angle = angle_ff;

endmodule

### rtl/core/quaternion_to_euler_angles_top.sv
// Quaternion to Z-Y-X Euler angles.
// Request channel: req_valid/req_ready with req_payload carrying w, x, y, z
// as signed Q1.14 (16384 = 1.0); the quaternion is used unnormalised.
// Response channel: rsp_valid/rsp_ready with roll, pitch and yaw in binary
// angle units (32768 = pi, +pi saturates to 32767).
// Stages in order: products, terms and the radicand, the square root for
// the pitch cosine, one fold stage, one stage per CORDIC step and one
// rounding stage.
// Throughput is one request per cycle when not stalled; every stage is a
// register stage and the three CORDIC units run side by side.
// Reset clears the valid bits of all stages; data registers are not reset.
// When the receiver holds rsp_ready low with a response waiting, the whole
// pipeline freezes, bubbles included, and req_ready drops; nothing is lost
// or repeated.
module quaternion_to_euler_angles_top
   import qte_pkg::*;
#(
   parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   localparam int Latency = 3 + SQRT_STEPS + CORDIC_STEPS + 2;

   logic                  en;
   logic [Latency-1:0]    vld_ff;
   logic [Latency-1:0]    vld_in;

   // pipeline advances unless the output is full and stalled
   assign en = !vld_ff[Latency-1] || rsp_ready;
   assign req_ready = en;
   assign vld_in = {vld_ff[Latency-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // stage 1: Q28 products
   logic signed [PROD_BITS-1:0] wx_ff, yz_ff, xx_ff, yy_ff, wy_ff, zx_ff, wz_ff, xy_ff, zz_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         wx_ff <= req_payload.quat_w * req_payload.quat_x;
         yz_ff <= req_payload.quat_y * req_payload.quat_z;
         xx_ff <= req_payload.quat_x * req_payload.quat_x;
         yy_ff <= req_payload.quat_y * req_payload.quat_y;
         wy_ff <= req_payload.quat_w * req_payload.quat_y;
         zx_ff <= req_payload.quat_z * req_payload.quat_x;
         wz_ff <= req_payload.quat_w * req_payload.quat_z;
         xy_ff <= req_payload.quat_x * req_payload.quat_y;
         zz_ff <= req_payload.quat_z * req_payload.quat_z;
      end
   end

   // stage 2: terms, pitch sine clamped to [-1, 1]
   logic signed [TERM_BITS-1:0] t0_ff, t1_ff, t3_ff, t4_ff;
   logic signed [SIN_BITS-1:0]  t2_ff;
   logic signed [TERM_BITS-1:0] t2_raw;

   assign t2_raw = 2 * (TERM_BITS'(wy_ff) - TERM_BITS'(zx_ff));

   always_ff @(posedge clock) begin
      if (en) begin
         t0_ff <= 2 * (TERM_BITS'(wx_ff) + TERM_BITS'(yz_ff));
         t1_ff <= ONE_Q28 - 2 * (TERM_BITS'(xx_ff) + TERM_BITS'(yy_ff));
         t3_ff <= 2 * (TERM_BITS'(wz_ff) + TERM_BITS'(xy_ff));
         t4_ff <= ONE_Q28 - 2 * (TERM_BITS'(yy_ff) + TERM_BITS'(zz_ff));
         if (t2_raw > ONE_Q28)
            t2_ff <= SIN_BITS'(ONE_Q28);
         else if (t2_raw < -ONE_Q28)
            t2_ff <= SIN_BITS'(-ONE_Q28);
         else
            t2_ff <= t2_raw[SIN_BITS-1:0];
      end
   end

   // stage 3: radicand 1 - s^2 in Q56
   logic signed [2*SIN_BITS-1:0] sq;
   logic [RAD_BITS-1:0]          rad_ff;

   assign sq = t2_ff * t2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff <= (RAD_BITS'(1) << 56) - sq[RAD_BITS-1:0];
      end
   end

   // terms ride alongside the radicand and the root
   logic signed [TERM_BITS-1:0] d0_ff [SQRT_STEPS+1];
   logic signed [TERM_BITS-1:0] d1_ff [SQRT_STEPS+1];
   logic signed [TERM_BITS-1:0] d3_ff [SQRT_STEPS+1];
   logic signed [TERM_BITS-1:0] d4_ff [SQRT_STEPS+1];
   logic signed [SIN_BITS-1:0]  d2_ff [SQRT_STEPS+1];

   always_ff @(posedge clock) begin
      if (en) begin
         d0_ff[0] <= t0_ff;
         d1_ff[0] <= t1_ff;
         d2_ff[0] <= t2_ff;
         d3_ff[0] <= t3_ff;
         d4_ff[0] <= t4_ff;
         for (int k = 1; k <= SQRT_STEPS; k++) begin
            d0_ff[k] <= d0_ff[k-1];
            d1_ff[k] <= d1_ff[k-1];
            d2_ff[k] <= d2_ff[k-1];
            d3_ff[k] <= d3_ff[k-1];
            d4_ff[k] <= d4_ff[k-1];
         end
      end
   end

   logic [ROOT_BITS-1:0] root;

   qte_isqrt u_isqrt (
      .clock (clock),
      .en    (en),
      .rad   (rad_ff),
      .root  (root)
   );

   // three CORDIC vectoring units in parallel
   logic signed [ANGLE_OUT_BITS-1:0] roll, pitch, yaw;

   qte_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll (
      .clock (clock),
      .en    (en),
      .y_in  (CORDIC_BITS'(d0_ff[SQRT_STEPS])),
      .x_in  (CORDIC_BITS'(d1_ff[SQRT_STEPS])),
      .angle (roll)
   );

   qte_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
      .clock (clock),
      .en    (en),
      .y_in  (CORDIC_BITS'(d2_ff[SQRT_STEPS])),
      .x_in  ($signed({{(CORDIC_BITS-ROOT_BITS){1'b0}}, root})),
      .angle (pitch)
   );

   qte_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
      .clock (clock),
      .en    (en),
      .y_in  (CORDIC_BITS'(d3_ff[SQRT_STEPS])),
      .x_in  (CORDIC_BITS'(d4_ff[SQRT_STEPS])),
      .angle (yaw)
   );

   assign rsp_valid = vld_ff[Latency-1];
   assign rsp_payload.roll_angle  = roll;
   assign rsp_payload.pitch_angle = pitch;
   assign rsp_payload.yaw_angle   = yaw;

endmodule

### bench/quaternion_to_euler_angles_top_test.sv
module quaternion_to_euler_angles_top_test;
   import qte_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_RANDOM = 1650;
   localparam int LATENCY = DEF_CORDIC_STEPS + 34;
   localparam int IDLE_LIMIT = 20000;
   localparam int N_DIRECTED = 16;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   rsp_payload_type angles_due[$];
   int errors = 0;
   int idle_cycles = 0;
   bit stimulus_done = 1'b0;

   // atan(2^-i), 2^31 = pi
   longint arctan_step[32] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41721, 20860, 10430, 5215, 2607, 1303, 651, 325, 162, 81, 40, 20,
      10, 5, 2, 1, 0, 0};

   // directed requests; expected angles typed in where obvious
   typedef struct {
      logic [15:0] w, x, y, z;
      bit known;
      logic [15:0] roll, pitch, yaw;
   } directed_row_type;

   directed_row_type directed_rows[N_DIRECTED] = '{
      '{16'd16384, 16'd0, 16'd0, 16'd0, 1, 16'd0, 16'd0, 16'd0},
      '{16'd0, 16'd0, 16'd0, 16'd0, 1, 16'd0, 16'd0, 16'd0},
      '{16'd0, 16'd16384, 16'd0, 16'd0, 1, 16'd32767, 16'd0, 16'd0},
      '{16'd0, 16'd0, 16'd0, 16'd16384, 1, 16'd0, 16'd0, 16'd32767},
      '{16'd0, 16'd0, 16'd16384, 16'd0, 0, 16'd0, 16'd0, 16'd0},
      '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0, 16'd0, 16'd0, 16'd0},
      '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, 16'd0, 16'd0, 16'd0},
      '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 0, 16'd0, 16'd0, 16'd0},
      '{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 0, 16'd0, 16'd0, 16'd0},
      '{16'd11585, 16'd0, 16'd11585, 16'd0, 0, 16'd0, 16'd0, 16'd0},
      '{16'd11585, 16'd0, 16'hd2bf, 16'd0, 0, 16'd0, 16'd0, 16'd0},
      '{16'h7fff, 16'd0, 16'h7fff, 16'd0, 0, 16'd0, 16'd0, 16'd0},
      '{16'h7fff, 16'd0, 16'h8000, 16'd0, 0, 16'd0, 16'd0, 16'd0},
      '{16'hffff, 16'h0001, 16'hffff, 16'h0001, 0, 16'd0, 16'd0, 16'd0},
      '{16'd8192, 16'd8192, 16'd8192, 16'd8192, 0, 16'd0, 16'd0, 16'd0},
      '{16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 0, 16'd0, 16'd0, 16'd0}};

   quaternion_to_euler_angles_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always #2 clock = ~clock;

   function automatic longint shift_down(longint v, int s);
      return v >>> s;
   endfunction

   // vectoring CORDIC, 2^31 = pi
   function automatic longint vector_angle(longint y, longint x);
      longint acc, dx, dy;
      acc = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         acc = (y >= 0) ? 64'sd2147483648 : -64'sd2147483648;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < DEF_CORDIC_STEPS; i++) begin
         dx = shift_down(y, i);
         dy = shift_down(x, i);
         if (y >= 0) begin
            x += dx;
            y -= dy;
            acc += arctan_step[i];
         end else begin
            x -= dx;
            y += dy;
            acc -= arctan_step[i];
         end
      end
      return acc;
   endfunction

   function automatic logic [15:0] to_binary_angle(longint a);
      longint r;
      r = shift_down(a + 32768, 16);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   function automatic longint root_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic rsp_payload_type euler_of(req_payload_type q);
      longint w, x, y, z, yy, t0, t1, t2, t3, t4, c;
      longint one;
      rsp_payload_type a;
      one = 64'sd1 << 28;
      w = q.quat_w;
      x = q.quat_x;
      y = q.quat_y;
      z = q.quat_z;
      // Q14 * Q14 is already Q28
      yy = y * y;
      t0 = 2 * (w * x + y * z);
      t1 = one - 2 * (x * x + yy);
      t2 = 2 * (w * y - z * x);
      t3 = 2 * (w * z + x * y);
      t4 = one - 2 * (yy + z * z);
      if (t2 > one) t2 = one;
      if (t2 < -one) t2 = -one;
      c = root_floor((64'd1 << 56) - longint'(t2 * t2));
      a.roll_angle = to_binary_angle(vector_angle(t0, t1));
      a.pitch_angle = to_binary_angle(vector_angle(t2, c));
      a.yaw_angle = to_binary_angle(vector_angle(t3, t4));
      return a;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, $signed(got),
         $signed(want), $realtime);
      errors++;
   endtask

   function automatic int random_gap();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   function automatic logic [15:0] random_component();
      case ($urandom_range(0, 5))
         0: return 16'(0);
         1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
         2: return $urandom_range(0, 1) ? 16'(16384) : 16'(-16384);
         3: return 16'($signed($urandom_range(0, 32768)) - 16384);
         default: return 16'($urandom);
      endcase
   endfunction

   // send one request and hold it until accepted
   task automatic send_request(req_payload_type q);
      req_valid <= 1'b1;
      req_payload <= q;
      do @(posedge clock); while (!req_ready);
      angles_due.push_back(euler_of(q));
   endtask

   // sender
   initial begin
      req_payload_type q;
      int gap;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < N_DIRECTED; i++) begin
         q.quat_w = directed_rows[i].w;
         q.quat_x = directed_rows[i].x;
         q.quat_y = directed_rows[i].y;
         q.quat_z = directed_rows[i].z;
         send_request(q);
         if (directed_rows[i].known) begin
            angles_due[$].roll_angle = directed_rows[i].roll;
            angles_due[$].pitch_angle = directed_rows[i].pitch;
            angles_due[$].yaw_angle = directed_rows[i].yaw;
         end
         req_valid <= 1'b0;
         @(posedge clock);
      end
      for (int i = 0; i < N_RANDOM; i++) begin
         q.quat_w = random_component();
         q.quat_x = random_component();
         q.quat_y = random_component();
         q.quat_z = random_component();
         send_request(q);
         gap = (i < 300) ? 0 : random_gap();
         // drain once mid-run
         if (i == 900) begin
            req_valid <= 1'b0;
            while (angles_due.size() != 0) @(posedge clock);
         end else if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
      stimulus_done = 1'b1;
   end

   // receiver: long hold-off early on, then random stalls
   initial begin
      int gap;
      repeat (7) @(posedge clock);
      rsp_ready <= 1'b1;
      repeat (40) @(posedge clock);
      rsp_ready <= 1'b0;
      repeat (200) @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         gap = random_gap();
         if ($urandom_range(0, 3) == 0) gap = 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // response checker and watchdog
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid && rsp_ready) begin
            if (angles_due.size() == 0) begin
               $display("unexpected response at %0t", $realtime);
               errors++;
            end else begin
               want = angles_due.pop_front();
               if (rsp_payload.roll_angle !== want.roll_angle)
                  report_mismatch("roll", rsp_payload.roll_angle, want.roll_angle);
               if (rsp_payload.pitch_angle !== want.pitch_angle)
                  report_mismatch("pitch", rsp_payload.pitch_angle, want.pitch_angle);
               if (rsp_payload.yaw_angle !== want.yaw_angle)
                  report_mismatch("yaw", rsp_payload.yaw_angle, want.yaw_angle);
            end
         end
      end
   end

   // end of run
   initial begin
      wait (stimulus_done);
      while (angles_due.size() != 0 && idle_cycles < IDLE_LIMIT) @(posedge clock);
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         repeat (2 * LATENCY) @(posedge clock);
         if (errors == 0 && angles_due.size() == 0) begin
            $display("PASS");
         end else begin
            $display("FAIL");
         end
         $finish;
      end
   end

   // watchdog while stimulus is still running
   initial begin
      wait (idle_cycles >= IDLE_LIMIT && !stimulus_done);
      $display("FAIL");
      $finish;
   end

endmodule

### filelist.f
rtl/core/qte_pkg.sv
rtl/core/qte_isqrt.sv
rtl/core/qte_cordic.sv
rtl/core/quaternion_to_euler_angles_top.sv
bench/quaternion_to_euler_angles_top_test.sv
